// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk; TLS_ASSERT is disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define TLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tls_pkg.sv =====
// ----------------------------------------------------------------------------
// Line splitter package
// Request and result types, function codes and character constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tls_pkg;

  localparam int unsigned LEN_W = 7;
  localparam int unsigned SLOTS = 3;

  localparam logic [1:0] FUNC_DATA    = 2'd0;
  localparam logic [1:0] FUNC_FLUSH   = 2'd1;
  localparam logic [1:0] FUNC_DISCARD = 2'd2;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] END_C = 2'd0;
  localparam logic [1:0] END_R = 2'd1;
  localparam logic [1:0] END_X = 2'd2;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    logic             out_kind;
    logic [7:0]       out_char;
    logic [1:0]       end_type;
    logic [LEN_W-1:0] line_length;
    logic             last_of_run;
  } res_t;

  // One result of a request, without its run marker.
  typedef struct packed {
    logic             kind;
    logic [7:0]       ch;
    logic [1:0]       end_type;
    logic [LEN_W-1:0] len;
  } slot_t;

  // All results caused by one request, in order of the set valid bits.
  typedef struct packed {
    logic [SLOTS-1:0] valid;
    slot_t [SLOTS-1:0] slot;
  } run_t;

endpackage

// ===== rtl/core/text_line_splitter.sv =====
// A request's results are registered in the run queue, behind older runs.
// Throughput: one request per cycle unless full; results leave one per cycle
// on pop (up to three per request); the single result port sets the drain rate.
// The run queue (QUEUE_DEPTH runs) absorbs bursts; full rises when it is full.
// Reset (rst, synchronous): line state cleared and the queue emptied; ready at once.
// ----------------------------------------------------------------------------
// Text line splitter
// Splits a byte stream into lines ended by CR, LF, CRLF, a full length or a flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_line_splitter #(
  parameter int unsigned LINE_LENGTH = 64,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  tls_pkg::req_t item,
  output logic          empty,
  input  logic          pop,
  output tls_pkg::res_t result
);

  tls_pkg::run_t run, head;
  logic          run_push, head_pop, head_empty, accept;

  assign accept = push && !full;

  tls_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (item),
    .accept   (accept),
    .run      (run),
    .run_push (run_push)
  );

  tls_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (run_push),
    .wr_data (run),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head),
    .empty   (head_empty)
  );

  tls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// ===== rtl/core/tls_front.sv =====
// ----------------------------------------------------------------------------
// Line splitter front end
// Holds the line state and turns each request into a run of up to three results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tls_front #(
  parameter int unsigned LINE_LENGTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  tls_pkg::req_t req,
  input  logic          accept,
  output tls_pkg::run_t run,
  output logic          run_push
);

  localparam logic [tls_pkg::LEN_W-1:0] LINE_MAX = tls_pkg::LEN_W'(LINE_LENGTH);

  logic [tls_pkg::LEN_W-1:0] char_count, char_count_next;
  logic                      cr_pending, cr_pending_next;
  logic                      nul_seen, nul_seen_next;

  logic [tls_pkg::LEN_W-1:0] base_count, inc_count;
  logic                      base_nul, nul_now;

  always_comb begin
    run             = '0;
    char_count_next = char_count;
    cr_pending_next = cr_pending;
    nul_seen_next   = nul_seen;
    // A held CR closes its line first, so a data byte starts from an empty line.
    base_count = cr_pending ? '0 : char_count;
    base_nul   = cr_pending ? 1'b0 : nul_seen;
    nul_now    = base_nul | (req.in_byte == tls_pkg::CHAR_NUL);
    inc_count  = base_count + tls_pkg::LEN_W'(1);
    case (req.func)
      tls_pkg::FUNC_DATA: begin
        if (cr_pending) begin
          run.valid[0]         = 1'b1;
          run.slot[0].kind     = tls_pkg::KIND_END;
          run.slot[0].end_type = (req.in_byte == tls_pkg::CHAR_LF) ? tls_pkg::END_X
                                                                    : tls_pkg::END_R;
          run.slot[0].len      = char_count;
        end
        char_count_next = '0;
        cr_pending_next = 1'b0;
        nul_seen_next   = 1'b0;
        if (cr_pending && req.in_byte == tls_pkg::CHAR_LF) begin
          // The LF completes a CRLF pair and is used up.
        end else if (req.in_byte == tls_pkg::CHAR_CR) begin
          char_count_next = base_count;
          nul_seen_next   = base_nul;
          cr_pending_next = 1'b1;
        end else if (req.in_byte == tls_pkg::CHAR_LF) begin
          run.valid[1]         = 1'b1;
          run.slot[1].kind     = tls_pkg::KIND_END;
          run.slot[1].end_type = tls_pkg::END_X;
          run.slot[1].len      = base_count;
        end else begin
          if (!nul_now) begin
            run.valid[1]     = 1'b1;
            run.slot[1].kind = tls_pkg::KIND_CHAR;
            run.slot[1].ch   = req.in_byte;
          end
          if (inc_count == LINE_MAX) begin
            run.valid[2]         = 1'b1;
            run.slot[2].kind     = tls_pkg::KIND_END;
            run.slot[2].end_type = tls_pkg::END_C;
            run.slot[2].len      = inc_count;
          end else begin
            char_count_next = inc_count;
            nul_seen_next   = nul_now;
          end
        end
      end
      tls_pkg::FUNC_FLUSH: begin
        if (cr_pending || char_count != '0) begin
          run.valid[0]         = 1'b1;
          run.slot[0].kind     = tls_pkg::KIND_END;
          run.slot[0].end_type = cr_pending ? tls_pkg::END_R : tls_pkg::END_C;
          run.slot[0].len      = char_count;
        end
        char_count_next = '0;
        cr_pending_next = 1'b0;
        nul_seen_next   = 1'b0;
      end
      tls_pkg::FUNC_DISCARD: begin
        char_count_next = '0;
        cr_pending_next = 1'b0;
        nul_seen_next   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign run_push = accept && (run.valid != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      cr_pending <= 1'b0;
      nul_seen   <= 1'b0;
    end else if (accept) begin
      char_count <= char_count_next;
      cr_pending <= cr_pending_next;
      nul_seen   <= nul_seen_next;
    end
  end

  `TLS_ASSERT_ALWAYS(a_count_below_max, rst || char_count < LINE_MAX, "line count reached the maximum")
  `TLS_ASSERT(a_nul_needs_chars, nul_seen |-> char_count != '0, "NUL flag set on an empty line")

endmodule

// ===== rtl/core/tls_queue.sv =====
// ----------------------------------------------------------------------------
// Line splitter run queue
// Short register queue of result runs between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tls_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  tls_pkg::run_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output tls_pkg::run_t rd_data,
  output logic          empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tls_pkg::run_t    store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `TLS_ASSERT(a_count_bound, count <= CNT_FULL, "queue count beyond depth")
  `TLS_ASSERT(a_count_step, do_wr && !do_rd |=> count == $past(count) + CNT_W'(1), "queue count did not step")

endmodule

// ===== rtl/core/tls_back.sv =====
// ----------------------------------------------------------------------------
// Line splitter back end
// Walks the valid slots of the oldest run and hands out one result per pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tls_back (
  input  logic          clk,
  input  logic          rst,
  input  tls_pkg::run_t head,
  input  logic          head_empty,
  output logic          head_pop,
  output tls_pkg::res_t result,
  output logic          empty,
  input  logic          pop
);

  logic [tls_pkg::SLOTS-1:0] done;
  logic [tls_pkg::SLOTS-1:0] pending, pick, after;
  tls_pkg::slot_t            cur;
  logic                      take;

  assign pending = head.valid & ~done;
  // Lowest remaining slot comes out first.
  assign pick    = pending & (~pending + tls_pkg::SLOTS'(1));
  assign after   = pending & ~pick;
  assign empty   = head_empty;
  assign take    = pop && !head_empty;

  always_comb begin
    case (pick)
      3'b001:  cur = head.slot[0];
      3'b010:  cur = head.slot[1];
      3'b100:  cur = head.slot[2];
      default: cur = head.slot[0];
    endcase
  end

  assign result.out_kind    = cur.kind;
  assign result.out_char    = cur.ch;
  assign result.end_type    = cur.end_type;
  assign result.line_length = cur.len;
  assign result.last_of_run = (after == '0);
  assign head_pop           = take && (after == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (take) begin
      done <= (after == '0) ? '0 : (done | pick);
    end
  end

  `TLS_ASSERT(a_head_has_work, !head_empty |-> pending != '0, "waiting run has no result left")
  `TLS_ASSERT(a_done_clears, head_pop |=> done == '0, "slot marks kept after a run left")

endmodule

// ===== tb/tls_line_checker.sv =====
// ----------------------------------------------------------------------------
// Line splitter checker
// Watches the request and result queues of the line splitter, predicts the
// characters and line ends that each accepted request causes, and compares
// every popped result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tls_line_checker #(
  parameter int unsigned LINE_LENGTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          full,
  input  tls_pkg::req_t item,
  input  logic          empty,
  input  logic          pop,
  input  tls_pkg::res_t result,
  output int            mismatches,
  output int            due_count
);
  import tls_pkg::*;

  // Predicted line state.
  logic [LEN_W-1:0] pos;
  logic             cr_held;
  logic             nul_hit;

  res_t line_results_due[$];

  task automatic close_line(input logic [1:0] kind_of_end);
    res_t r;
    r = '0;
    r.out_kind = KIND_END;
    r.end_type = kind_of_end;
    r.line_length = pos;
    line_results_due.push_back(r);
    pos = '0;
    cr_held = 1'b0;
    nul_hit = 1'b0;
  endtask

  task automatic predict_line_results(input req_t r);
    int   due_at_start;
    logic lf_eaten;
    res_t c;
    due_at_start = line_results_due.size();
    lf_eaten = 1'b0;
    case (r.func)
      FUNC_DISCARD: begin
        pos = '0;
        cr_held = 1'b0;
        nul_hit = 1'b0;
      end
      FUNC_FLUSH: begin
        if (cr_held) close_line(END_R);
        else if (pos != '0) close_line(END_C);
      end
      FUNC_DATA: begin
        // A held CR is settled by this byte: an LF joins it, anything else
        // closes the line first and then starts a new one.
        if (cr_held) begin
          if (r.in_byte == CHAR_LF) begin
            close_line(END_X);
            lf_eaten = 1'b1;
          end else begin
            close_line(END_R);
          end
        end
        if (!lf_eaten) begin
          if (r.in_byte == CHAR_CR) begin
            cr_held = 1'b1;
          end else if (r.in_byte == CHAR_LF) begin
            close_line(END_X);
          end else begin
            if (r.in_byte == CHAR_NUL) nul_hit = 1'b1;
            if (!nul_hit) begin
              c = '0;
              c.out_kind = KIND_CHAR;
              c.out_char = r.in_byte;
              line_results_due.push_back(c);
            end
            pos = pos + 1'b1;
            if (pos >= LINE_LENGTH) close_line(END_C);
          end
        end
      end
      default: begin
      end
    endcase
    if (line_results_due.size() > due_at_start) begin
      c = line_results_due.pop_back();
      c.last_of_run = 1'b1;
      line_results_due.push_back(c);
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (line_results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result kind %0d char %h end %0d len %0d last %0d",
                 $realtime, got.out_kind, got.out_char, got.end_type,
                 got.line_length, got.last_of_run);
    end else begin
      want = line_results_due.pop_front();
      if (got.out_kind !== want.out_kind || got.out_char !== want.out_char ||
          got.end_type !== want.end_type || got.line_length !== want.line_length ||
          got.last_of_run !== want.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch, expected kind %0d char %h end %0d len %0d last %0d, got kind %0d char %h end %0d len %0d last %0d",
                   $realtime, want.out_kind, want.out_char, want.end_type,
                   want.line_length, want.last_of_run, got.out_kind, got.out_char,
                   got.end_type, got.line_length, got.last_of_run);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos = '0;
      cr_held = 1'b0;
      nul_hit = 1'b0;
      line_results_due.delete();
      mismatches = 0;
    end else begin
      // Results popped now belong to earlier requests, so check before predicting.
      if (pop && !empty) check_result(result);
      if (push && !full) predict_line_results(item);
    end
    due_count <= line_results_due.size();
  end

endmodule

// ===== tb/text_line_splitter_tb.sv =====
// ----------------------------------------------------------------------------
// Line splitter testbench
// Feeds the splitter a directed set of line endings, NUL, flush, discard and unused-code cases,
// then random lines of mixed length and ending, with random gaps on both
// queues, a long stall of the result side and a full drain part-way through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_line_splitter_tb;
  import tls_pkg::*;

  localparam int unsigned LINE_LEN    = 64;
  localparam int          ITEM_TARGET = 300;
  localparam int          HOLD_CYCLES = 80;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic push;
  logic full;
  req_t item;
  logic empty;
  logic pop;
  res_t result;

  int mismatches;
  int due_count;
  int sent;
  bit calm;
  bit hold_req;

  text_line_splitter #(
    .LINE_LENGTH(LINE_LEN)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  tls_line_checker #(
    .LINE_LENGTH(LINE_LEN)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .mismatches(mismatches),
    .due_count(due_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("text_line_splitter_tb: done, errors");
    $finish;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 27);
  endfunction

  task automatic send_req(input logic [1:0] f, input logic [7:0] b);
    req_t r;
    r.func = f;
    r.in_byte = b;
    while (take_break()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    item <= r;
    push <= 1'b1;
    do @(posedge clk); while (full);
    if (f != FUNC_UNUSED) sent++;
  endtask

  // Mostly ordinary characters, now and then a NUL or any byte at all.
  function automatic logic [7:0] line_char();
    int         p;
    logic [7:0] b;
    p = $urandom_range(0, 99);
    b = 8'($urandom_range(1, 255));
    if (p < 5) return CHAR_NUL;
    if (p < 8) return 8'($urandom_range(0, 255));
    if (b == CHAR_CR || b == CHAR_LF) b = 8'h41;
    return b;
  endfunction

  task automatic send_line(input int len, input int ending);
    int n;
    for (int i = 0; i < len; i++) send_req(FUNC_DATA, line_char());
    if (ending < 30) begin
      send_req(FUNC_DATA, CHAR_LF);
    end else if (ending < 55) begin
      send_req(FUNC_DATA, CHAR_CR);
      send_req(FUNC_DATA, CHAR_LF);
    end else if (ending < 75) begin
      send_req(FUNC_DATA, CHAR_CR);
    end else if (ending < 85) begin
      send_req(FUNC_FLUSH, 8'($urandom_range(0, 255)));
    end else if (ending < 90) begin
      send_req(FUNC_DISCARD, 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  // Result side: random pops, and once a long hold-off so the queue fills.
  initial begin : rx_side
    bit held;
    held = 1'b0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= !take_break();
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int  p;
    int  len;
    bit  drained;
    drained = 1'b0;
    sent = 0;
    calm <= 1'b0;
    hold_req <= 1'b0;
    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Byte extremes closed by LF, then an empty LF line and an empty CRLF line.
    send_req(FUNC_DATA, 8'h7F);
    send_req(FUNC_DATA, 8'hFF);
    send_req(FUNC_DATA, 8'h01);
    send_req(FUNC_DATA, CHAR_LF);
    send_req(FUNC_DATA, CHAR_LF);
    send_req(FUNC_DATA, CHAR_CR);
    send_req(FUNC_DATA, CHAR_LF);
    // A held CR followed by an ordinary byte, then CR after CR, then a flush
    // that closes the held CR.
    send_req(FUNC_DATA, 8'h61);
    send_req(FUNC_DATA, CHAR_CR);
    send_req(FUNC_DATA, 8'h62);
    send_req(FUNC_DATA, CHAR_CR);
    send_req(FUNC_DATA, CHAR_CR);
    send_req(FUNC_FLUSH, 8'h00);
    // A flush of an empty line gives nothing.
    send_req(FUNC_FLUSH, 8'hFF);
    // NUL hides itself and the rest of the line but still counts.
    send_req(FUNC_DATA, 8'h71);
    send_req(FUNC_DATA, CHAR_NUL);
    send_req(FUNC_DATA, 8'h7A);
    send_req(FUNC_FLUSH, 8'h5A);
    // Discard drops the partial line silently.
    send_req(FUNC_DATA, 8'h6B);
    send_req(FUNC_DISCARD, 8'hA5);
    send_req(FUNC_DATA, CHAR_LF);
    // The unused function code is ignored.
    send_req(FUNC_UNUSED, 8'hAA);
    send_req(FUNC_DATA, 8'h6D);
    send_req(FUNC_UNUSED, 8'h55);
    send_req(FUNC_DATA, CHAR_LF);
    drain_results();

    // A line of exactly the full length, then CRLF closing an empty line.
    send_line(LINE_LEN, 30);
    while (sent < ITEM_TARGET) begin
      if (sent >= 60 && !hold_req) hold_req <= 1'b1;
      if (sent >= 150 && !drained) begin
        drain_results();
        drained = 1'b1;
      end
      calm <= (sent >= 200 && sent < 260);
      p = $urandom_range(0, 99);
      if (p < 65) len = $urandom_range(0, 12);
      else if (p < 85) len = $urandom_range(60, 72);
      else len = $urandom_range(13, 59);
      send_line(len, $urandom_range(0, 99));
    end

    push <= 1'b0;
    calm <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_line_splitter_tb: done, clean");
    end else begin
      $display("text_line_splitter_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tls_pkg.sv
rtl/core/tls_front.sv
rtl/core/tls_queue.sv
rtl/core/tls_back.sv
rtl/core/text_line_splitter.sv
tb/tls_line_checker.sv
tb/text_line_splitter_tb.sv
